[rtl/assert_macros.svh]
// Assertion macros for the deframer RTL, included by the back end.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("deframer assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("deframer assertion failed");

`endif

[rtl/imd_pkg.sv]
// Types, constants and the title key table shared by the deframer modules.
`default_nettype none
package imd_pkg;

	localparam int StrideBitsDefault = 20;
	localparam int QueueDepthDefault = 4;
	localparam logic [31:0] StrideReset = 32'd8192;
	localparam int MetaLeftBits = 12;
	localparam logic [3:0] KeyLen = 4'd13;
	localparam logic [7:0] QuoteChar = 8'h27;

	typedef enum logic [1:0] {
		CLASS_AUDIO  = 2'd0,
		CLASS_LENGTH = 2'd1,
		CLASS_META   = 2'd2,
		CLASS_TITLE  = 2'd3
	} class_t;

	typedef enum logic [1:0] {
		MODE_SEARCH = 2'd0,
		MODE_TITLE  = 2'd1,
		MODE_DONE   = 2'd2
	} mode_t;

	typedef struct packed {
		logic [7:0] value;
		class_t     kind;
		logic       last;
	} token_t;

	function automatic logic [7:0] key_char(input logic [3:0] idx);
		logic [7:0] c;
		unique case (idx)
			4'd0:    c = "S";
			4'd1:    c = "t";
			4'd2:    c = "r";
			4'd3:    c = "e";
			4'd4:    c = "a";
			4'd5:    c = "m";
			4'd6:    c = "T";
			4'd7:    c = "i";
			4'd8:    c = "t";
			4'd9:    c = "l";
			4'd10:   c = "e";
			4'd11:   c = "=";
			4'd12:   c = QuoteChar;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

[rtl/imd_front.sv]
// Framing front end: splits the stream into audio, length and metadata bytes.
`default_nettype none
module imd_front
	import imd_pkg::*;
#(
	parameter int STRIDE_BITS = StrideBitsDefault
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [STRIDE_BITS-1:0] cfg_wdata,
	input  wire logic                   take,
	input  wire logic [7:0]             stream_byte,
	output token_t                      tok
);

	logic [STRIDE_BITS-1:0]  stride_q;
	logic [STRIDE_BITS-1:0]  audio_left_q;
	logic                    in_meta_q;
	logic [MetaLeftBits-1:0] meta_left_q;
	logic                    last_byte;

	assign last_byte = (meta_left_q == MetaLeftBits'(1));

	always_comb begin
		tok.value = stream_byte;
		tok.last  = 1'b0;
		if (in_meta_q) begin
			tok.kind = CLASS_META;
			tok.last = last_byte;
		end else if (audio_left_q != '0) begin
			tok.kind = CLASS_AUDIO;
		end else begin
			tok.kind = CLASS_LENGTH;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stride_q     <= STRIDE_BITS'(StrideReset);
			audio_left_q <= STRIDE_BITS'(StrideReset);
			in_meta_q    <= 1'b0;
			meta_left_q  <= '0;
		end else begin
			if (cfg_we) begin
				stride_q <= cfg_wdata;
			end
			if (take) begin
				if (in_meta_q) begin
					meta_left_q <= meta_left_q - 1'b1;
					if (last_byte) begin
						in_meta_q    <= 1'b0;
						audio_left_q <= stride_q;
					end
				end else if (audio_left_q != '0) begin
					audio_left_q <= audio_left_q - 1'b1;
				end else if (stream_byte == 8'h00) begin
					audio_left_q <= stride_q;
				end else begin
					in_meta_q   <= 1'b1;
					meta_left_q <= {stream_byte, 4'b0000};
				end
			end
		end
	end

endmodule
`default_nettype wire

[rtl/imd_queue.sv]
// Short show-ahead queue of classified bytes between the front and back ends.
`default_nettype none
module imd_queue
	import imd_pkg::*;
#(
	parameter int DEPTH = QueueDepthDefault
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   wr_en,
	input  wire token_t wr_tok,
	output logic        full,
	input  wire logic   rd_en,
	output token_t      rd_tok,
	output logic        empty
);

	localparam int IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	token_t          mem [DEPTH];
	logic [IdxW-1:0] wr_ptr_q;
	logic [IdxW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign full   = (count_q == CntW'(DEPTH));
	assign empty  = (count_q == '0);
	assign rd_tok = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_ptr_q] <= wr_tok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == IdxW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == IdxW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

[rtl/imd_back.sv]
// Title search back end with the result register.
`default_nettype none
module imd_back
	import imd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       q_empty,
	input  wire token_t     q_tok,
	output logic            q_rd,
	output logic            empty,
	input  wire logic       pop,
	output logic [1:0]      byte_class,
	output logic [7:0]      byte_value,
	output logic            title_end,
	output logic            title_abort
);

	`include "assert_macros.svh"

	mode_t      mode_q;
	mode_t      mode_step;
	mode_t      mode_next;
	logic [3:0] match_pos_q;
	logic [3:0] match_next;
	logic [3:0] pos;
	logic [3:0] pos_adv;
	logic       res_valid_q;
	class_t     class_d;
	logic       end_d;
	logic       abort_d;
	class_t     class_q;
	logic [7:0] value_q;
	logic       end_q;
	logic       abort_q;

	assign q_rd    = !q_empty && (!res_valid_q || pop);
	assign pos     = (match_pos_q < KeyLen) ? match_pos_q : 4'd0;
	assign pos_adv = (q_tok.value == key_char(pos)) ? pos + 4'd1 :
		(q_tok.value == key_char(4'd0)) ? 4'd1 : 4'd0;

	always_comb begin
		mode_step  = mode_q;
		match_next = match_pos_q;
		if (q_tok.kind == CLASS_META) begin
			unique case (mode_q)
				MODE_SEARCH: begin
					if (q_tok.value == 8'h00) begin
						mode_step = MODE_DONE;
					end else if (pos_adv >= KeyLen) begin
						mode_step  = MODE_TITLE;
						match_next = 4'd0;
					end else begin
						match_next = pos_adv;
					end
				end
				MODE_TITLE: begin
					if (q_tok.value == QuoteChar || q_tok.value == 8'h00) begin
						mode_step = MODE_DONE;
					end
				end
				default: begin
					mode_step = mode_q;
				end
			endcase
		end
		mode_next = mode_step;
		if (q_tok.last) begin
			mode_next  = MODE_SEARCH;
			match_next = 4'd0;
		end
	end

	always_comb begin
		class_d = q_tok.kind;
		end_d   = 1'b0;
		abort_d = 1'b0;
		if (q_tok.kind == CLASS_META && mode_q == MODE_TITLE) begin
			if (q_tok.value == QuoteChar) begin
				end_d = 1'b1;
			end else if (q_tok.value == 8'h00) begin
				abort_d = 1'b1;
			end else begin
				class_d = CLASS_TITLE;
			end
		end
		if (q_tok.last && mode_step == MODE_TITLE) begin
			abort_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_SEARCH;
			match_pos_q <= 4'd0;
			res_valid_q <= 1'b0;
		end else begin
			if (q_rd) begin
				mode_q      <= mode_next;
				match_pos_q <= match_next;
				res_valid_q <= 1'b1;
			end else if (pop) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_rd) begin
			class_q <= class_d;
			value_q <= q_tok.value;
			end_q   <= end_d;
			abort_q <= abort_d;
		end
	end

	assign empty       = !res_valid_q;
	assign byte_class  = class_q;
	assign byte_value  = value_q;
	assign title_end   = end_q;
	assign title_abort = abort_q;

	`ASSERT_IMPL(a_flags_exclusive, res_valid_q, !(end_q && abort_q))
	`ASSERT_IMPL(a_title_no_end, res_valid_q && class_q == CLASS_TITLE, !end_q)
	`ASSERT_IMPL(a_title_pos_clear, mode_q == MODE_TITLE, match_pos_q == 4'd0)
	`ASSERT_NEXT(a_last_resets_search, q_rd && q_tok.last, mode_q == MODE_SEARCH)

endmodule
`default_nettype wire

[rtl/icy_metadata_deframer.sv]
// Top level of the interleaved audio/metadata deframer with stream title search.
//
//   Channel   Direction  Handshake            Payload
//   input     in         push / full          stream_byte
//   result    out        empty / pop          byte_class, byte_value, title_end, title_abort
//   config    in         cfg_we (no stall)    cfg_wdata (audio stride)
//
// One byte per clock is taken unless full; results pass the queue and the result register.
// The framing counters in the front end close their loop in one cycle per byte.
// A queue of QUEUE_DEPTH entries plus the result register absorb a stalled result side.
// Reset is asynchronous and leaves the stride at 8192 with an empty pipeline.
`default_nettype none
module icy_metadata_deframer
	import imd_pkg::*;
#(
	parameter int STRIDE_BITS = StrideBitsDefault,
	parameter int QUEUE_DEPTH = QueueDepthDefault
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [STRIDE_BITS-1:0] cfg_wdata,
	input  wire logic                   push,
	output logic                        full,
	input  wire logic [7:0]             stream_byte,
	output logic                        empty,
	input  wire logic                   pop,
	output logic [1:0]                  byte_class,
	output logic [7:0]                  byte_value,
	output logic                        title_end,
	output logic                        title_abort
);

	token_t front_tok;
	token_t q_tok;
	logic   take;
	logic   q_rd;
	logic   q_empty;

	assign take = push && !full;

	imd_front #(
		.STRIDE_BITS(STRIDE_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.take       (take),
		.stream_byte(stream_byte),
		.tok        (front_tok)
	);

	imd_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.wr_en (take),
		.wr_tok(front_tok),
		.full  (full),
		.rd_en (q_rd),
		.rd_tok(q_tok),
		.empty (q_empty)
	);

	imd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_tok      (q_tok),
		.q_rd       (q_rd),
		.empty      (empty),
		.pop        (pop),
		.byte_class (byte_class),
		.byte_value (byte_value),
		.title_end  (title_end),
		.title_abort(title_abort)
	);

endmodule
`default_nettype wire

[sim/testbench.sv]
// Self-checking testbench for the audio/metadata deframer and its stream title search.
`default_nettype none
module testbench;
	import imd_pkg::*;

	localparam int StrideBits = StrideBitsDefault;
	localparam logic [StrideBits-1:0] StrideMax = '1;
	localparam int CycleLimit = 1000000;
	localparam int HoldCycles = 80;
	localparam int RandomItems = 1150;
	localparam int PhaseCount = 8;

	typedef struct packed {
		class_t     kind;
		logic [7:0] value;
		logic       t_end;
		logic       t_abort;
	} byte_result_t;

	class deframe_scoreboard;
		string title_key = "StreamTitle='";
		logic [StrideBits-1:0] stride = StrideReset[StrideBits-1:0];
		logic [StrideBits-1:0] audio_left = StrideReset[StrideBits-1:0];
		bit in_block = 1'b0;
		logic [MetaLeftBits-1:0] block_left = '0;
		int key_pos = 0;
		mode_t mode = MODE_SEARCH;
		byte_result_t pending_results[$];
		int errors = 0;
		int results_seen = 0;
		int blocks_seen = 0;
		int titles_closed = 0;
		int titles_aborted = 0;

		function void report(string msg);
			errors++;
			if (errors <= 20)
				$display("mismatch at %0t: %s", $time, msg);
		endfunction

		function void set_stride(logic [StrideBits-1:0] v);
			stride = v;
		endfunction

		function int pending();
			return pending_results.size();
		endfunction

		function void accept_byte(logic [7:0] b);
			byte_result_t r;
			int p;
			r = '{CLASS_AUDIO, b, 1'b0, 1'b0};
			if (!in_block) begin
				if (audio_left != 0) begin
					audio_left = audio_left - 1'b1;
				end else begin
					r.kind = CLASS_LENGTH;
					if (b == 8'h00) begin
						audio_left = stride;
					end else begin
						in_block = 1'b1;
						block_left = {b, 4'h0};
						key_pos = 0;
						mode = MODE_SEARCH;
						blocks_seen++;
					end
				end
			end else begin
				r.kind = CLASS_META;
				case (mode)
					MODE_SEARCH: begin
						if (b == 8'h00) begin
							mode = MODE_DONE;
						end else begin
							p = (key_pos < title_key.len()) ? key_pos : 0;
							if (b == title_key[p])
								p++;
							else
								p = (b == title_key[0]) ? 1 : 0;
							if (p >= title_key.len()) begin
								mode = MODE_TITLE;
								p = 0;
							end
							key_pos = p;
						end
					end
					MODE_TITLE: begin
						if (b == QuoteChar) begin
							r.t_end = 1'b1;
							mode = MODE_DONE;
						end else if (b == 8'h00) begin
							r.t_abort = 1'b1;
							mode = MODE_DONE;
						end else begin
							r.kind = CLASS_TITLE;
						end
					end
					default: ;
				endcase
				block_left = block_left - 1'b1;
				if (block_left == 0) begin
					if (mode == MODE_TITLE)
						r.t_abort = 1'b1;
					in_block = 1'b0;
					audio_left = stride;
					mode = MODE_SEARCH;
					key_pos = 0;
				end
			end
			if (r.t_end)
				titles_closed++;
			if (r.t_abort)
				titles_aborted++;
			pending_results.push_back(r);
		endfunction

		function void check_result(logic [1:0] kind, logic [7:0] value, logic t_end,
				logic t_abort);
			byte_result_t want;
			results_seen++;
			if (pending_results.size() == 0) begin
				report($sformatf("unexpected result, class %0d value %02h", kind, value));
				return;
			end
			want = pending_results.pop_front();
			if (kind !== want.kind)
				report($sformatf("result %0d: class %0d, expected %0d", results_seen, kind,
					want.kind));
			if (value !== want.value)
				report($sformatf("result %0d: value %02h, expected %02h", results_seen, value,
					want.value));
			if (t_end !== want.t_end)
				report($sformatf("result %0d: title_end %b, expected %b", results_seen, t_end,
					want.t_end));
			if (t_abort !== want.t_abort)
				report($sformatf("result %0d: title_abort %b, expected %b", results_seen,
					t_abort, want.t_abort));
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [StrideBits-1:0] cfg_wdata;
	logic push;
	logic full;
	logic [7:0] stream_byte;
	logic empty;
	logic pop;
	logic [1:0] byte_class;
	logic [7:0] byte_value;
	logic title_end;
	logic title_abort;

	deframe_scoreboard sb = new();
	string title_key = "StreamTitle='";
	logic [7:0] frame_q[$];
	logic [StrideBits-1:0] phase_strides[PhaseCount] = '{0, 1, 5, 0, 2, 23, 1, 0};
	int burst_left = 0;
	int items_sent = 0;
	int big_blocks = 2;
	int holds_done = 0;
	int cycle_count = 0;

	icy_metadata_deframer uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.push(push),
		.full(full),
		.stream_byte(stream_byte),
		.empty(empty),
		.pop(pop),
		.byte_class(byte_class),
		.byte_value(byte_value),
		.title_end(title_end),
		.title_abort(title_abort)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("run did not finish within %0d cycles", CycleLimit);
			$display("FAILED: results differ");
			$finish;
		end else if (arst_n && pop && !empty) begin
			sb.check_result(byte_class, byte_value, title_end, title_abort);
		end
	end

	function automatic logic [7:0] rand_byte();
		return ($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom);
	endfunction

	function automatic logic [7:0] text_char();
		return ($urandom_range(0, 2) == 0) ? 8'($urandom_range(8'h20, 8'h7e))
			: 8'(title_key[$urandom_range(0, 12)]);
	endfunction

	function automatic logic [7:0] title_char();
		logic [7:0] c;
		do
			c = 8'($urandom_range(1, 255));
		while (c == QuoteChar);
		return c;
	endfunction

	task automatic send_byte(input logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 200)
				: $urandom_range(1, 24);
			gap = $urandom_range(0, 8);
			if (gap != 0) begin
				@(negedge clk);
				push <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		@(negedge clk);
		push <= 1'b1;
		stream_byte <= b;
		do
			@(posedge clk);
		while (full);
		sb.accept_byte(b);
		burst_left--;
		items_sent++;
	endtask

	task automatic idle_input();
		@(negedge clk);
		push <= 1'b0;
		burst_left = 0;
	endtask

	task automatic write_stride(input logic [StrideBits-1:0] v);
		idle_input();
		while (sb.pending() != 0)
			@(posedge clk);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		sb.set_stride(v);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic add_text(input string s);
		foreach (s[i])
			frame_q.push_back(s[i]);
	endtask

	// Sends random bytes up to the next length byte, then the length byte and the padded block.
	task automatic send_block();
		int blocks;
		while (sb.in_block || sb.audio_left != 0)
			send_byte(rand_byte());
		blocks = (frame_q.size() + 15) / 16;
		while (frame_q.size() < blocks * 16)
			frame_q.push_back(8'h00);
		send_byte(8'(blocks));
		foreach (frame_q[i])
			send_byte(frame_q[i]);
		frame_q.delete();
	endtask

	task automatic build_block(input int n);
		int form;
		int k;
		form = $urandom_range(0, 5);
		if (form == 0) begin
			repeat (n) frame_q.push_back(rand_byte());
			return;
		end
		repeat ($urandom_range(0, 6)) frame_q.push_back(text_char());
		if (form == 4) begin
			k = $urandom_range(1, 12);
			for (int i = 0; i < k; i++)
				frame_q.push_back(title_key[i]);
			frame_q.push_back(text_char());
		end
		if (form == 5)
			frame_q.push_back(8'h00);
		add_text(title_key);
		if (form == 2) begin
			while (frame_q.size() < n)
				frame_q.push_back(title_char());
		end else begin
			repeat ($urandom_range(0, 20)) frame_q.push_back(title_char());
			frame_q.push_back((form == 3) ? 8'h00 : QuoteChar);
		end
		while (frame_q.size() > n)
			void'(frame_q.pop_back());
		while (frame_q.size() < n)
			frame_q.push_back($urandom_range(0, 1) ? 8'h00 : rand_byte());
	endtask

	task automatic send_random_frame();
		int pick;
		int n;
		pick = $urandom_range(0, 99);
		if (sb.in_block || pick < 10) begin
			repeat ($urandom_range(1, 24)) send_byte(rand_byte());
			return;
		end
		if (pick < 16) begin
			n = 0;
		end else if (pick < 18 && big_blocks > 0) begin
			big_blocks--;
			n = 16 * ($urandom_range(0, 1) ? 255 : $urandom_range(4, 254));
		end else begin
			n = 16 * $urandom_range(1, 3);
		end
		if (n != 0)
			build_block(n);
		send_block();
	endtask

	initial begin
		int seg_left;
		int rx_mode;
		int next_hold;
		seg_left = 0;
		rx_mode = 0;
		next_hold = 300;
		pop = 1'b0;
		forever begin
			@(negedge clk);
			if (sb.results_seen >= next_hold) begin
				next_hold += 1500;
				holds_done++;
				pop <= 1'b0;
				repeat (HoldCycles) @(negedge clk);
			end
			if (seg_left == 0) begin
				seg_left = $urandom_range(16, 160);
				rx_mode = $urandom_range(0, 3);
			end
			seg_left--;
			case (rx_mode)
				0: pop <= 1'b1;
				1: pop <= 1'($urandom_range(0, 1));
				2: pop <= ($urandom_range(0, 3) == 0);
				default: pop <= ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	initial begin
		int phase_end;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		push = 1'b0;
		stream_byte = 8'h00;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// The reset stride governs the first audio run; the new value applies at the first reload.
		write_stride(3);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_block();
		add_text("StreamTitle='AB'");
		send_block();
		add_text("SStreamTitle='");
		frame_q.push_back(8'hFF);
		add_text("''StreamTitle='x'");
		send_block();
		add_text("ab");
		frame_q.push_back(8'h00);
		add_text("StreamTitle='t'");
		send_block();
		add_text("StreamTitle='z");
		frame_q.push_back(8'h00);
		add_text("q");
		send_block();
		add_text("StreamTitle='abc");
		send_block();
		add_text("xyzStreamTitle='");
		send_block();
		add_text("StreamTitStreamTitle='ok'");
		send_block();

		foreach (phase_strides[i]) begin
			write_stride(phase_strides[i]);
			phase_end = items_sent + RandomItems / PhaseCount;
			while (items_sent < phase_end)
				send_random_frame();
		end

		// An open block is closed under the zero stride, so the next byte is a length byte.
		while (sb.in_block)
			send_byte(rand_byte());

		// The widest stride is reached last, since a full run of it would not fit the run.
		write_stride(StrideMax);
		build_block(16);
		send_block();
		repeat (200) send_byte(rand_byte());

		idle_input();
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		$display("Checked %0d bytes over %0d metadata blocks: %0d titles closed, %0d discarded.",
			sb.results_seen, sb.blocks_seen, sb.titles_closed, sb.titles_aborted);
		$display("Strides from 0 to %0d were used, with %0d long stalls on the result side.",
			StrideMax, holds_done);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
`default_nettype wire
